[hdl/collinear_triple_finder_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the collinear triple finder RTL (used in ctf_datapath).
// Both expect clk and rst_n in scope of the module that uses them.
// ---------------------------------------------------------------------------
`ifndef COLLINEAR_TRIPLE_FINDER_ASSERT_SVH
`define COLLINEAR_TRIPLE_FINDER_ASSERT_SVH

// same-cycle implication
`define CTF_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("collinear_triple_finder: assertion failed");

// next-cycle implication
`define CTF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("collinear_triple_finder: assertion failed");

`endif

[hdl/ctf_pkg.sv]
// ---------------------------------------------------------------------------
// ctf_pkg
// Types and constants of the collinear triple finder.
// ---------------------------------------------------------------------------
`default_nettype none

package ctf_pkg;

    localparam int DIMENSIONS  = 5;
    localparam int POINTS      = 3 ** DIMENSIONS;
    localparam int MAP_DEPTH   = 256;
    localparam int ADDR_W      = $clog2(MAP_DEPTH);
    localparam int LIMIT       = (POINTS < MAP_DEPTH) ? POINTS : MAP_DEPTH;
    localparam int CNT_W       = $clog2(LIMIT + 1);
    localparam int KB_W        = $clog2(POINTS);
    localparam int CMP_W       = (KB_W > CNT_W) ? KB_W : CNT_W;
    localparam int PT_W        = 8;
    localparam int CAP_W       = 7;
    localparam int MAX_RESULTS = 64;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_CHECK = 1'b1;

    typedef struct packed {
        logic            req_type;
        logic [PT_W-1:0] point_index;
        logic            selected;
    } req_t;

    typedef struct packed {
        logic [PT_W-1:0] first_point;
        logic [PT_W-1:0] second_point;
        logic [PT_W-1:0] third_point;
        logic            found;
        logic            truncated;
        logic            last_result;
    } rsp_t;

    typedef enum logic [2:0] {
        EMIT_NONE,
        EMIT_MID,
        EMIT_TRUNC,
        EMIT_LAST,
        EMIT_EMPTY
    } emit_t;

    typedef struct packed {
        logic  clr_en;
        logic  load_wr;
        logic  start;
        logic  i_rd;
        logic  j_rd;
        logic  k_rd;
        logic  i_inc;
        logic  j_init;
        logic  j_inc;
        logic  k_capture;
        logic  push;
        emit_t emit;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic i_end;
        logic j_end;
        logic k_ok;
        logic map_bit;
        logic pend_valid;
        logic cap_hit;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

[hdl/ctf_ram.sv]
// ---------------------------------------------------------------------------
// ctf_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module ctf_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[hdl/ctf_datapath.sv]
// ---------------------------------------------------------------------------
// ctf_datapath
// Walk counters, third-point logic, pending result, output register, map.
// ---------------------------------------------------------------------------
`default_nettype none

`include "collinear_triple_finder_assert.svh"

module ctf_datapath (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire ctf_pkg::cmd_t             cmd,
    output ctf_pkg::sts_t                  sts,
    input  wire ctf_pkg::req_t             req,
    output ctf_pkg::rsp_t                  rsp,
    output logic                           rsp_valid,
    input  wire logic                      rsp_stall,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [ctf_pkg::CAP_W-1:0] cfg_data
);

    typedef logic [ctf_pkg::DIMENSIONS-1:0][1:0] digs_t;

    // base-3 increment, ripple over the digits
    function automatic digs_t digs_inc(input digs_t a);
        digs_t r;
        logic  c;
        r = a;
        c = 1'b1;
        for (int d = 0; d < ctf_pkg::DIMENSIONS; d++)
        begin
            if (c)
            begin
                if (a[d] == 2'd2)
                begin
                    r[d] = 2'd0;
                end
                else
                begin
                    r[d] = a[d] + 2'd1;
                    c    = 1'b0;
                end
            end
        end
        return r;
    endfunction

    // digitwise -(a+b) mod 3
    function automatic digs_t digs_third(input digs_t a, input digs_t b);
        digs_t      r;
        logic [2:0] s;
        for (int d = 0; d < ctf_pkg::DIMENSIONS; d++)
        begin
            s = {1'b0, a[d]} + {1'b0, b[d]};
            case (s)
                3'd0, 3'd3: r[d] = 2'd0;
                3'd1, 3'd4: r[d] = 2'd2;
                3'd2:       r[d] = 2'd1;
                default:    r[d] = 2'd0;
            endcase
        end
        return r;
    endfunction

    function automatic logic [ctf_pkg::KB_W-1:0] digs_to_bin(input digs_t a);
        logic [ctf_pkg::KB_W-1:0] acc;
        acc = '0;
        for (int d = ctf_pkg::DIMENSIONS - 1; d >= 0; d--)
        begin
            acc = ctf_pkg::KB_W'({acc, 1'b0}) + acc + ctf_pkg::KB_W'(a[d]);
        end
        return acc;
    endfunction

    logic [ctf_pkg::CNT_W-1:0]  i_reg, i_next, j_reg, j_next;
    digs_t                      i_dig_reg, i_dig_next, j_dig_reg, j_dig_next;
    logic [ctf_pkg::KB_W-1:0]   k_reg, k_next;
    logic [ctf_pkg::PT_W-1:0]   pa_reg, pa_next, pb_reg, pb_next, pc_reg, pc_next;
    logic                       pend_valid_reg, pend_valid_next;
    logic [ctf_pkg::CAP_W-1:0]  count_reg, count_next;
    logic [ctf_pkg::ADDR_W-1:0] clr_reg, clr_next;
    logic [ctf_pkg::CAP_W-1:0]  cfg_reg, cfg_next;
    ctf_pkg::rsp_t              out_reg, out_next;
    logic                       out_valid_reg, out_valid_next;

    logic [ctf_pkg::CAP_W-1:0]  cap;
    logic                       out_free;
    logic                       k_ok;
    logic                       in_range;
    logic                       ram_we, ram_wdata, ram_re, ram_rdata;
    logic [ctf_pkg::ADDR_W-1:0] ram_waddr, ram_raddr;

    // effective cap: zero acts as one, saturates at the result limit
    always_comb
    begin
        if (cfg_reg == '0)
        begin
            cap = ctf_pkg::CAP_W'(1);
        end
        else if (cfg_reg > ctf_pkg::CAP_W'(ctf_pkg::MAX_RESULTS))
        begin
            cap = ctf_pkg::CAP_W'(ctf_pkg::MAX_RESULTS);
        end
        else
        begin
            cap = cfg_reg;
        end
    end

    assign out_free = !out_valid_reg || !rsp_stall;
    assign k_ok     = (ctf_pkg::CMP_W'(k_reg) > ctf_pkg::CMP_W'(j_reg))
                   && (ctf_pkg::CMP_W'(k_reg) < ctf_pkg::CMP_W'(ctf_pkg::LIMIT));
    assign in_range = {1'b0, req.point_index} < 9'(ctf_pkg::LIMIT);

    // map ports: write is the clearing pass or a load, read is the walk
    always_comb
    begin
        ram_we    = cmd.clr_en || (cmd.load_wr && in_range);
        ram_waddr = cmd.clr_en ? clr_reg : ctf_pkg::ADDR_W'(req.point_index);
        ram_wdata = cmd.clr_en ? 1'b0 : req.selected;
        ram_re    = cmd.i_rd || cmd.j_rd || cmd.k_rd;
        if (cmd.i_rd)
        begin
            ram_raddr = ctf_pkg::ADDR_W'(i_reg);
        end
        else if (cmd.j_rd)
        begin
            ram_raddr = ctf_pkg::ADDR_W'(j_reg);
        end
        else
        begin
            ram_raddr = ctf_pkg::ADDR_W'(k_reg);
        end
    end

    ctf_ram #(
        .WIDTH (1),
        .DEPTH (ctf_pkg::MAP_DEPTH)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        i_next          = i_reg;
        i_dig_next      = i_dig_reg;
        j_next          = j_reg;
        j_dig_next      = j_dig_reg;
        k_next          = k_reg;
        pa_next         = pa_reg;
        pb_next         = pb_reg;
        pc_next         = pc_reg;
        pend_valid_next = pend_valid_reg;
        count_next      = count_reg;
        clr_next        = cmd.clr_en ? clr_reg + 1'b1 : clr_reg;
        cfg_next        = cfg_valid ? cfg_data : cfg_reg;

        if (cmd.start)
        begin
            i_next          = '0;
            i_dig_next      = '0;
            count_next      = '0;
            pend_valid_next = 1'b0;
        end
        if (cmd.i_inc)
        begin
            i_next     = i_reg + 1'b1;
            i_dig_next = digs_inc(i_dig_reg);
        end
        if (cmd.j_init)
        begin
            j_next     = i_reg + 1'b1;
            j_dig_next = digs_inc(i_dig_reg);
        end
        if (cmd.j_inc)
        begin
            j_next     = j_reg + 1'b1;
            j_dig_next = digs_inc(j_dig_reg);
        end
        if (cmd.k_capture)
        begin
            k_next = digs_to_bin(digs_third(i_dig_reg, j_dig_reg));
        end
        if (cmd.push)
        begin
            pa_next         = ctf_pkg::PT_W'(i_reg);
            pb_next         = ctf_pkg::PT_W'(j_reg);
            pc_next         = ctf_pkg::PT_W'(k_reg);
            pend_valid_next = 1'b1;
            count_next      = count_reg + 1'b1;
        end

        out_next             = out_reg;
        out_next.first_point  = pa_reg;
        out_next.second_point = pb_reg;
        out_next.third_point  = pc_reg;
        out_next.found        = 1'b1;
        out_next.truncated    = 1'b0;
        out_next.last_result  = 1'b0;
        case (cmd.emit)
            ctf_pkg::EMIT_MID:
            begin
            end
            ctf_pkg::EMIT_TRUNC:
            begin
                out_next.truncated   = 1'b1;
                out_next.last_result = 1'b1;
            end
            ctf_pkg::EMIT_LAST:
            begin
                out_next.last_result = 1'b1;
            end
            ctf_pkg::EMIT_EMPTY:
            begin
                out_next             = '0;
                out_next.last_result = 1'b1;
            end
            default:
            begin
                out_next = out_reg;
            end
        endcase

        if (cmd.emit != ctf_pkg::EMIT_NONE)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && rsp_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg          <= '0;
            i_dig_reg      <= '0;
            j_reg          <= '0;
            j_dig_reg      <= '0;
            pend_valid_reg <= 1'b0;
            count_reg      <= '0;
            clr_reg        <= '0;
            cfg_reg        <= ctf_pkg::CAP_W'(ctf_pkg::MAX_RESULTS);
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            i_reg          <= i_next;
            i_dig_reg      <= i_dig_next;
            j_reg          <= j_next;
            j_dig_reg      <= j_dig_next;
            pend_valid_reg <= pend_valid_next;
            count_reg      <= count_next;
            clr_reg        <= clr_next;
            cfg_reg        <= cfg_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg   <= k_next;
        pa_reg  <= pa_next;
        pb_reg  <= pb_next;
        pc_reg  <= pc_next;
        out_reg <= out_next;
    end

    always_comb
    begin
        sts.clr_last   = clr_reg == ctf_pkg::ADDR_W'(ctf_pkg::MAP_DEPTH - 1);
        sts.i_end      = i_reg >= ctf_pkg::CNT_W'(ctf_pkg::LIMIT);
        sts.j_end      = j_reg >= ctf_pkg::CNT_W'(ctf_pkg::LIMIT);
        sts.k_ok       = k_ok;
        sts.map_bit    = ram_rdata;
        sts.pend_valid = pend_valid_reg;
        sts.cap_hit    = count_reg >= cap;
        sts.out_free   = out_free;
    end

    assign rsp       = out_reg;
    assign rsp_valid = out_valid_reg;
    assign cfg_ready = 1'b1;

    `CTF_ASSERT_IMPL(a_emit_has_room, cmd.emit != ctf_pkg::EMIT_NONE, out_free)
    `CTF_ASSERT_IMPL(a_pend_counted, pend_valid_reg, count_reg != '0)
    `CTF_ASSERT_IMPL(a_probe_above_j, cmd.k_rd, k_ok)
    `CTF_ASSERT_IMPL(a_empty_is_last, out_valid_reg && !out_reg.found, out_reg.last_result)

endmodule

`default_nettype wire

[hdl/ctf_ctrl.sv]
// ---------------------------------------------------------------------------
// ctf_ctrl
// Sequencer: map clearing pass, load requests and the pair walk of a check.
// ---------------------------------------------------------------------------
`default_nettype none

module ctf_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    input  wire logic          req_type,
    output logic               req_stall,
    output ctf_pkg::cmd_t      cmd,
    input  wire ctf_pkg::sts_t sts
);

    typedef enum logic [8:0] {
        S_CLEAR  = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_I_ADDR = 9'b000000100,
        S_I_CHK  = 9'b000001000,
        S_J_ADDR = 9'b000010000,
        S_J_CHK  = 9'b000100000,
        S_K_ADDR = 9'b001000000,
        S_K_CHK  = 9'b010000000,
        S_FINISH = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.emit   = ctf_pkg::EMIT_NONE;
        req_stall  = 1'b1;

        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_en = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    if (req_type == ctf_pkg::REQ_CHECK)
                    begin
                        cmd.start  = 1'b1;
                        state_next = S_I_ADDR;
                    end
                    else
                    begin
                        cmd.load_wr = 1'b1;
                    end
                end
            end
            S_I_ADDR:
            begin
                if (sts.i_end)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.i_rd   = 1'b1;
                    state_next = S_I_CHK;
                end
            end
            S_I_CHK:
            begin
                if (sts.map_bit)
                begin
                    cmd.j_init = 1'b1;
                    state_next = S_J_ADDR;
                end
                else
                begin
                    cmd.i_inc  = 1'b1;
                    state_next = S_I_ADDR;
                end
            end
            S_J_ADDR:
            begin
                if (sts.j_end)
                begin
                    cmd.i_inc  = 1'b1;
                    state_next = S_I_ADDR;
                end
                else
                begin
                    cmd.j_rd   = 1'b1;
                    state_next = S_J_CHK;
                end
            end
            S_J_CHK:
            begin
                if (sts.map_bit)
                begin
                    cmd.k_capture = 1'b1;
                    state_next    = S_K_ADDR;
                end
                else
                begin
                    cmd.j_inc  = 1'b1;
                    state_next = S_J_ADDR;
                end
            end
            S_K_ADDR:
            begin
                if (sts.k_ok)
                begin
                    cmd.k_rd   = 1'b1;
                    state_next = S_K_CHK;
                end
                else
                begin
                    cmd.j_inc  = 1'b1;
                    state_next = S_J_ADDR;
                end
            end
            S_K_CHK:
            begin
                if (!sts.map_bit)
                begin
                    cmd.j_inc  = 1'b1;
                    state_next = S_J_ADDR;
                end
                else if (sts.cap_hit)
                begin
                    // one triple past the cap: flag the held result and stop
                    if (sts.out_free)
                    begin
                        cmd.emit   = ctf_pkg::EMIT_TRUNC;
                        state_next = S_IDLE;
                    end
                end
                else if (sts.pend_valid)
                begin
                    if (sts.out_free)
                    begin
                        cmd.emit   = ctf_pkg::EMIT_MID;
                        cmd.push   = 1'b1;
                        cmd.j_inc  = 1'b1;
                        state_next = S_J_ADDR;
                    end
                end
                else
                begin
                    cmd.push   = 1'b1;
                    cmd.j_inc  = 1'b1;
                    state_next = S_J_ADDR;
                end
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = sts.pend_valid ? ctf_pkg::EMIT_LAST : ctf_pkg::EMIT_EMPTY;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

[hdl/collinear_triple_finder.sv]
// Load request: accepted back to back while idle, no result.
// Check request: walks each selected outer point and each inner point above it in the map;
// for each selected pair the third point is computed and, if above the inner point and in
// range, probed through the one map read port; a result leaves when the next triple is found,
// the last at walk end. The walk covers all 243 points and is held while rsp_stall blocks.
// Reset: clearing pass over all 256 map entries with req_stall high; cfg always taken.
// ---------------------------------------------------------------------------
// collinear_triple_finder
// Finds collinear point triples in a selected subset of the ternary space.
// ---------------------------------------------------------------------------
`default_nettype none

module collinear_triple_finder (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire ctf_pkg::req_t             req,
    input  wire logic                      req_valid,
    output logic                           req_stall,
    output ctf_pkg::rsp_t                  rsp,
    output logic                           rsp_valid,
    input  wire logic                      rsp_stall,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [ctf_pkg::CAP_W-1:0] cfg_data
);

    ctf_pkg::cmd_t cmd;
    ctf_pkg::sts_t sts;

    ctf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_type  (req.req_type),
        .req_stall (req_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    ctf_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .req       (req),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

endmodule

`default_nettype wire

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// Collinear triple finder testbench
// Drives load and check requests into the finder and predicts every result
// from a local copy of the selection map and the report cap. Mismatches are
// reported as they occur. The run covers a directed part, cap settings, random
// traffic under three stall profiles, a long receiver hold-off and a dense subspace.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_CYCLES = 500000;
    localparam int SETTLE_CYCLES   = 20;
    localparam int TAIL_CYCLES     = 64;

    logic clk = 1'b0;
    logic rst_n;
    ctf_pkg::req_t req;
    logic req_valid;
    logic req_stall;
    ctf_pkg::rsp_t rsp;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    logic cfg_valid;
    logic cfg_ready;
    logic [ctf_pkg::CAP_W-1:0] cfg_data;

    // predictor state
    bit   chosen [ctf_pkg::MAP_DEPTH];
    int   report_cap = ctf_pkg::MAX_RESULTS;
    ctf_pkg::rsp_t expected_lines [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left     = 0;
    int items_sent    = 0;
    int errors        = 0;
    int idle_cycles   = 0;

    collinear_triple_finder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // third point on the line through a and b, digit by digit mod 3
    function automatic int third_on_line(input int a, input int b);
        int k;
        int place;
        int d;
        k = 0;
        place = 1;
        for (d = 0; d < ctf_pkg::DIMENSIONS; d++)
        begin
            k += ((6 - a % 3 - b % 3) % 3) * place;
            place *= 3;
            a /= 3;
            b /= 3;
        end
        return k;
    endfunction

    function automatic void predict_lines();
        ctf_pkg::rsp_t batch [ctf_pkg::MAX_RESULTS];
        int   cap;
        int   hits;
        int   i;
        int   j;
        int   k;
        bit   stop;
        cap = report_cap;
        if (cap == 0)
            cap = 1;
        if (cap > ctf_pkg::MAX_RESULTS)
            cap = ctf_pkg::MAX_RESULTS;
        hits = 0;
        stop = 1'b0;
        for (i = 0; i < ctf_pkg::LIMIT && !stop; i++)
        begin
            if (!chosen[i])
                continue;
            for (j = i + 1; j < ctf_pkg::LIMIT && !stop; j++)
            begin
                if (!chosen[j])
                    continue;
                k = third_on_line(i, j);
                if (k <= j || k >= ctf_pkg::LIMIT || !chosen[k])
                    continue;
                if (hits >= cap)
                begin
                    batch[hits-1].truncated = 1'b1;
                    stop = 1'b1;
                end
                else
                begin
                    batch[hits].first_point  = i[ctf_pkg::PT_W-1:0];
                    batch[hits].second_point = j[ctf_pkg::PT_W-1:0];
                    batch[hits].third_point  = k[ctf_pkg::PT_W-1:0];
                    batch[hits].found        = 1'b1;
                    batch[hits].truncated    = 1'b0;
                    batch[hits].last_result  = 1'b0;
                    hits++;
                end
            end
        end
        if (hits == 0)
        begin
            batch[0] = '0;
            batch[0].last_result = 1'b1;
            hits = 1;
        end
        else
            batch[hits-1].last_result = 1'b1;
        for (i = 0; i < hits; i++)
            expected_lines.push_back(batch[i]);
    endfunction

    // Called right after a falling edge; returns right after one, valid left high.
    task automatic send_request(input logic kind, input int idx, input logic sel);
        ctf_pkg::req_t r;
        r.req_type    = kind;
        r.point_index = idx[ctf_pkg::PT_W-1:0];
        r.selected    = sel;
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req       <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        items_sent++;
        if (kind == ctf_pkg::REQ_CHECK)
            predict_lines();
        else if (idx < ctf_pkg::LIMIT)
            chosen[idx] = sel;
        @(negedge clk);
    endtask

    task automatic load_point(input int idx, input logic sel);
        send_request(ctf_pkg::REQ_LOAD, idx, sel);
    endtask

    task automatic run_check();
        send_request(ctf_pkg::REQ_CHECK, 0, 1'b0);
    endtask

    // loads leave no result behind, so let the block settle after the drain
    task automatic drain_and_settle();
        req_valid <= 1'b0;
        while (expected_lines.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_cap(input int value);
        cfg_data  <= value[ctf_pkg::CAP_W-1:0];
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        report_cap = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_cap(input int value);
        drain_and_settle();
        write_cap(value);
    endtask

    task automatic test_directed();
        run_check();                    // empty map: no triple
        load_point(0, 1'b1);
        load_point(1, 1'b1);
        load_point(2, 1'b1);
        load_point(243, 1'b1);          // out of range, ignored
        load_point(255, 1'b1);
        run_check();
        load_point(121, 1'b1);
        load_point(242, 1'b1);
        run_check();
        load_point(1, 1'b0);
        load_point(170, 1'b1);
        run_check();
        load_point(170, 1'b0);
        load_point(121, 1'b0);
        load_point(242, 1'b0);
    endtask

    // 0..8 span a plane with exactly 12 lines
    task automatic test_report_cap();
        int p;
        for (p = 1; p < 9; p++)
            load_point(p, 1'b1);
        set_cap(0);
        run_check();
        set_cap(1);
        run_check();
        set_cap(12);
        run_check();
        set_cap(11);
        run_check();
    endtask

    task automatic test_random_traffic(input int target);
        int n;
        int idx;
        int start;
        int p;
        int cleared;
        while (items_sent < target)
        begin
            if ($urandom_range(99, 0) < 70)
            begin
                n = $urandom_range(10, 2);
                repeat (n)
                begin
                    if ($urandom_range(99, 0) < 8)
                        idx = $urandom_range(255, ctf_pkg::LIMIT);
                    else
                        idx = $urandom_range(ctf_pkg::LIMIT - 1, 0);
                    load_point(idx, $urandom_range(99, 0) < 45);
                end
            end
            else
            begin
                start = $urandom_range(ctf_pkg::LIMIT - 1, 0);
                cleared = 0;
                for (p = 0; p < ctf_pkg::LIMIT && cleared < 8; p++)
                begin
                    if (chosen[(start + p) % ctf_pkg::LIMIT])
                    begin
                        load_point((start + p) % ctf_pkg::LIMIT, 1'b0);
                        cleared++;
                    end
                end
            end
            run_check();
            if ($urandom_range(99, 0) < 10)
                set_cap($urandom_range(127, 0));
        end
    endtask

    // results are held back while requests keep coming, so the block backs up
    task automatic test_backpressure();
        int n;
        drain_and_settle();
        load_point(0, 1'b1);
        load_point(3, 1'b1);
        load_point(6, 1'b1);
        hold_left = 3000;
        run_check();
        for (n = 0; n < 12; n++)
            load_point($urandom_range(ctf_pkg::LIMIT - 1, 0), 1'($urandom_range(1, 0)));
        run_check();
        drain_and_settle();
    endtask

    // 27 points of a 3-cube give 117 lines, well above any cap
    task automatic test_dense_subspace();
        int p;
        for (p = 0; p < 27; p++)
            load_point(p, 1'b1);
        set_cap(127);
        run_check();
        set_cap(65);
        run_check();
        set_cap(64);
        run_check();
    endtask

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            rsp_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else
            rsp_stall <= ($urandom_range(99, 0) < recv_idle_pct);
    end

    always @(posedge clk)
    begin : check_results
        ctf_pkg::rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_lines.size() == 0)
            begin
                $display("%0t ns: unexpected result: expected none, %s %0d %0d %0d f=%0b t=%0b l=%0b",
                         $time, "got", rsp.first_point, rsp.second_point, rsp.third_point,
                         rsp.found, rsp.truncated, rsp.last_result);
                errors++;
            end
            else
            begin
                want = expected_lines.pop_front();
                if (rsp !== want)
                begin
                    $display("%0t ns: mismatch: expected %0d %0d %0d f=%0b t=%0b l=%0b, %s",
                             $time, want.first_point, want.second_point, want.third_point,
                             want.found, want.truncated, want.last_result, "got");
                    $display("    %0d %0d %0d f=%0b t=%0b l=%0b",
                             rsp.first_point, rsp.second_point, rsp.third_point,
                             rsp.found, rsp.truncated, rsp.last_result);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_CYCLES)
            begin
                $display("watchdog: no transfer for %0d cycles", WATCHDOG_CYCLES);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        req       = '0;
        req_valid = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct = 9;
        recv_idle_pct = 68;
        test_directed();
        test_report_cap();
        set_cap(ctf_pkg::MAX_RESULTS);
        test_random_traffic(150);

        drain_and_settle();
        send_idle_pct = 68;
        recv_idle_pct = 9;
        test_random_traffic(270);
        test_backpressure();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(380);
        test_dense_subspace();

        drain_and_settle();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (errors == 0 && expected_lines.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
